### rtl/fals_pkg.sv
package fals_pkg;

  // Store geometry
  localparam int LINES      = 8;
  localparam int WIDTH      = 8;
  localparam int COORD_BITS = 10;

  // Fixed field widths of the channels
  localparam int MAT_W       = 2;
  localparam int COORD_IN_W  = 10;
  localparam int VAL_W       = 32;
  localparam int WIDX_IN_W   = 3;
  localparam int LINE_OUT_W  = 3;

  // Derived widths
  localparam int LINE_W = $clog2(LINES);
  localparam int WIDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic {
    REQ_QUERY  = 1'b0,
    REQ_INSERT = 1'b1
  } req_type_e;

  // One stored matrix element
  typedef struct packed {
    logic [MAT_W-1:0]      mat;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [VAL_W-1:0]      val;
  } elem_word_t;

  typedef elem_word_t [WIDTH-1:0] line_t;

  // Controller to datapath
  typedef struct packed {
    logic stage_wr;
    logic query_start;
    logic scan_step;
    logic hit_done;
    logic miss_done;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query_req;
    logic ins_ok;
    logic ins_last;
    logic match;
    logic last_line;
  } status_t;

  // Result payload
  typedef struct packed {
    logic                  is_query;
    logic                  hit;
    logic [LINE_OUT_W-1:0] line_used;
    logic                  evicted;
  } res_t;

endpackage

### rtl/fals_req_if.sv
interface fals_req_if
  import fals_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [MAT_W-1:0]       matrix_id;
  logic [COORD_IN_W-1:0]  row_index;
  logic [COORD_IN_W-1:0]  col_index;
  logic signed [VAL_W-1:0] elem_value;
  logic [WIDX_IN_W-1:0]   word_index;

  modport source (
    output valid, req_type, matrix_id, row_index, col_index, elem_value, word_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, matrix_id, row_index, col_index, elem_value, word_index,
    output ready
  );
endinterface

### rtl/fals_rsp_if.sv
interface fals_rsp_if
  import fals_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  is_query;
  logic                  hit;
  logic [LINE_OUT_W-1:0] line_used;
  logic                  evicted;

  modport source (
    output valid, is_query, hit, line_used, evicted,
    input  ready
  );

  modport sink (
    input  valid, is_query, hit, line_used, evicted,
    output ready
  );
endinterface

### rtl/fully_associative_lru_line_store.sv
// Query: compares one line per cycle, all words of the line in parallel, stopping at the
//   first hit; the result is registered once the scan ends and the result slot is free.
// Insert word: staged on acceptance; the last word of a line commits once the result slot is free.
// Transactions: one at a time, the next accepted in the cycle after the result is
//   registered; an insert word that does not end a line leaves the store ready for the next word.
// Reset clears the valid bits and recency ranks; line and staging storage is not cleared.
module fully_associative_lru_line_store
  import fals_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fals_req_if.sink   req_i,
  fals_rsp_if.source rsp_o
);

  cmd_t    cmd;
  status_t status;
  res_t    res;

  fals_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fals_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_i.req_type),
    .matrix_id_i  (req_i.matrix_id),
    .row_index_i  (req_i.row_index),
    .col_index_i  (req_i.col_index),
    .elem_value_i (req_i.elem_value),
    .word_index_i (req_i.word_index),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_o        (res)
  );

  assign rsp_o.is_query  = res.is_query;
  assign rsp_o.hit       = res.hit;
  assign rsp_o.line_used = res.line_used;
  assign rsp_o.evicted   = res.evicted;

endmodule

### rtl/fals_ctrl.sv
module fals_ctrl
  import fals_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   res_load;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // Sequence one transaction at a time
  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    res_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.is_query_req) begin
            cmd_o.query_start = 1'b1;
            state_d           = ST_SCAN;
          end else if (status_i.ins_ok) begin
            cmd_o.stage_wr = 1'b1;
            if (status_i.ins_last) begin
              state_d = ST_COMMIT;
            end
          end
        end
      end
      ST_SCAN: begin
        if (status_i.match) begin
          if (out_free) begin
            cmd_o.hit_done = 1'b1;
            res_load       = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (status_i.last_line) begin
          if (out_free) begin
            cmd_o.miss_done = 1'b1;
            res_load        = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          res_load     = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold a result until the sink takes it
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/fals_dp.sv
module fals_dp
  import fals_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_type_i,
  input  logic [MAT_W-1:0]        matrix_id_i,
  input  logic [COORD_IN_W-1:0]   row_index_i,
  input  logic [COORD_IN_W-1:0]   col_index_i,
  input  logic signed [VAL_W-1:0] elem_value_i,
  input  logic [WIDX_IN_W-1:0]    word_index_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  output res_t                    res_o
);

  // Line storage, one full line per row
  line_t      line_mem [LINES];
  line_t      rdata_q;

  elem_word_t staging_q [WIDTH];
  line_t      stage_line;

  elem_word_t qword_q;
  elem_word_t in_word;
  logic [LINE_W-1:0] scan_idx_q;
  logic [LINE_W-1:0] scan_nxt;
  logic [LINE_W-1:0] rd_addr;
  logic              rd_en;

  logic [LINES-1:0]  line_valid_q, line_valid_d;
  logic [LINE_W-1:0] line_age_q [LINES];
  logic [LINE_W-1:0] line_age_d [LINES];

  logic [COORD_BITS+COORD_IN_W-1:0] row_ext, col_ext;
  logic [WIDX_W+WIDX_IN_W-1:0]      widx_ext;
  logic [WIDX_W-1:0]                widx;

  logic              any_eq;
  logic              empty_found;
  logic [LINE_W-1:0] empty_idx;
  logic [LINE_W-1:0] oldest_idx;
  logic [LINE_W-1:0] oldest_age;
  logic [LINE_W-1:0] victim;
  logic              touch_en;
  logic [LINE_W-1:0] touch_idx;
  logic [LINE_W+LINE_OUT_W-1:0] hit_line_ext, victim_ext;

  res_t res_q;

  localparam logic [LINE_W-1:0] AGE_MAX  = LINE_W'(LINES - 1);
  localparam logic [LINE_W-1:0] LAST_IDX = LINE_W'(LINES - 1);

  // Form the incoming element, coordinates cut to COORD_BITS
  assign row_ext     = {{COORD_BITS{1'b0}}, row_index_i};
  assign col_ext     = {{COORD_BITS{1'b0}}, col_index_i};
  assign in_word.mat = matrix_id_i;
  assign in_word.row = row_ext[COORD_BITS-1:0];
  assign in_word.col = col_ext[COORD_BITS-1:0];
  assign in_word.val = elem_value_i;

  assign widx_ext = {{WIDX_W{1'b0}}, word_index_i};
  assign widx     = widx_ext[WIDX_W-1:0];

  // Report request kind and scan progress
  assign status_o.is_query_req = (req_type_i == REQ_QUERY);
  assign status_o.ins_ok       = (int'(word_index_i) < WIDTH);
  assign status_o.ins_last     = (int'(word_index_i) == WIDTH - 1);
  assign status_o.last_line    = (scan_idx_q == LAST_IDX);

  // Compare all words of the current line in parallel
  always_comb begin
    any_eq = 1'b0;
    for (int j = 0; j < WIDTH; j++) begin
      if (rdata_q[j] == qword_q) begin
        any_eq = 1'b1;
      end
    end
  end

  assign status_o.match = line_valid_q[scan_idx_q] && any_eq;

  // Stage words of the incoming line
  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_wr) begin
      staging_q[widx] <= in_word;
    end
  end

  always_comb begin
    for (int j = 0; j < WIDTH; j++) begin
      stage_line[j] = staging_q[j];
    end
  end

  // Advance the scan one line per cycle
  assign scan_nxt = status_o.last_line ? '0 : scan_idx_q + LINE_W'(1);
  assign rd_en    = cmd_i.query_start || cmd_i.scan_step;
  assign rd_addr  = cmd_i.query_start ? '0 : scan_nxt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      qword_q    <= in_word;
      scan_idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      line_mem[victim] <= stage_line;
    end
  end

  // Pick the first empty line, else the oldest (lowest index on a tie)
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (!line_valid_q[i]) begin
        empty_found = 1'b1;
        empty_idx   = LINE_W'(i);
      end
    end
    oldest_idx = '0;
    oldest_age = line_age_q[0];
    for (int i = 1; i < LINES; i++) begin
      if (line_age_q[i] > oldest_age) begin
        oldest_age = line_age_q[i];
        oldest_idx = LINE_W'(i);
      end
    end
  end

  assign victim = empty_found ? empty_idx : oldest_idx;

  // Make the touched line most recent and age the lines newer than it
  assign touch_en  = cmd_i.hit_done || cmd_i.commit;
  assign touch_idx = cmd_i.commit ? victim : scan_idx_q;

  always_comb begin
    line_valid_d = line_valid_q;
    line_age_d   = line_age_q;
    if (touch_en) begin
      for (int k = 0; k < LINES; k++) begin
        if ((LINE_W'(k) != touch_idx) && line_valid_q[k] &&
            (!line_valid_q[touch_idx] || (line_age_q[k] < line_age_q[touch_idx])) &&
            (line_age_q[k] != AGE_MAX)) begin
          line_age_d[k] = line_age_q[k] + LINE_W'(1);
        end
      end
      line_age_d[touch_idx]   = '0;
      line_valid_d[touch_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_valid_q <= '0;
      for (int k = 0; k < LINES; k++) begin
        line_age_q[k] <= '0;
      end
    end else begin
      line_valid_q <= line_valid_d;
      line_age_q   <= line_age_d;
    end
  end

  // Load the result register
  assign hit_line_ext = {{LINE_OUT_W{1'b0}}, scan_idx_q};
  assign victim_ext   = {{LINE_OUT_W{1'b0}}, victim};

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_done) begin
      res_q.is_query  <= 1'b1;
      res_q.hit       <= 1'b1;
      res_q.line_used <= hit_line_ext[LINE_OUT_W-1:0];
      res_q.evicted   <= 1'b0;
    end else if (cmd_i.miss_done) begin
      res_q.is_query  <= 1'b1;
      res_q.hit       <= 1'b0;
      res_q.line_used <= '0;
      res_q.evicted   <= 1'b0;
    end else if (cmd_i.commit) begin
      res_q.is_query  <= 1'b0;
      res_q.hit       <= 1'b0;
      res_q.line_used <= victim_ext[LINE_OUT_W-1:0];
      res_q.evicted   <= !empty_found;
    end
  end

  assign res_o = res_q;

  // A hit is only reported for a matching valid line
  a_hit_needs_match: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit_done |-> status_o.match
  ) else $error("hit reported without a matching valid line");

  // A committed line is valid and most recent afterwards
  a_commit_mru: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (line_valid_q[$past(victim)] && (line_age_q[$past(victim)] == '0))
  ) else $error("committed line not valid and most recent");

  // A hit line becomes most recent
  a_hit_mru: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit_done |=> (line_age_q[$past(scan_idx_q)] == '0)
  ) else $error("hit line not made most recent");

  // Eviction only replaces a valid line
  a_evict_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !empty_found) |-> line_valid_q[victim]
  ) else $error("eviction chose an empty line");

endmodule
